// File: rtl/core/qslerp_pkg.sv
package qslerp_pkg;

    // Fraction bits of the quaternion components (Q2.14).
    localparam int FRAC = 14;
    // Trig angles and weights are Q30.
    localparam int Q30 = 30;
    // CORDIC iterations of the acos and sine units.
    localparam int TRIG_ITER = 16;
    // One result bit per square root step, one quotient bit per divider step.
    localparam int SQ_STEPS = 31;
    localparam int DIV_STEPS = 30;
    // Width of the signed CORDIC datapath.
    localparam int CW = 34;

    // Pipeline positions inside the back end.
    localparam int IX_VEC = SQ_STEPS;
    localparam int IX_ANG = IX_VEC + TRIG_ITER + 1;
    localparam int IX_DIV = IX_ANG + TRIG_ITER + 1;
    localparam int IX_MUL = IX_DIV + DIV_STEPS + 1;
    localparam int STAGES = IX_MUL + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [14:0] THR_RESET = 15'd16;

    // Arctangent table, atan(2^-i) in Q30 radians.
    localparam logic [30:0] ATAN_Q30 [0:29] = '{
        31'd843314857, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
        31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
        31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535,
        31'd32767, 31'd16383, 31'd8191, 31'd4095, 31'd2047,
        31'd1024, 31'd512, 31'd256, 31'd128, 31'd64,
        31'd32, 31'd16, 31'd8, 31'd4, 31'd2
    };

    // One classified pair as it travels from the front end to the back end.
    typedef struct packed {
        logic [3:0][15:0] qa;   // first quaternion, x to w
        logic [3:0][16:0] qb;   // second quaternion, negated for the short arc
        logic [15:0]      t;    // blend fraction, clamped to one
        logic [14:0]      d;    // absolute dot product, clamped to one
        logic             req;  // one minus the absolute dot exceeds the threshold
    } item_t;

endpackage

// File: rtl/core/qslerp_front.sv
module qslerp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [143:0]         in_data,
    input  logic [14:0]          thr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qslerp_pkg::item_t    out_item
);

    logic signed [17:0] p_reg [4];
    logic [3:0][15:0]   a_reg;
    logic [3:0][15:0]   b_reg;
    logic [15:0]        t_reg;
    logic               v1_reg;
    logic               v2_reg;
    qslerp_pkg::item_t  item_reg;
    qslerp_pkg::item_t  item_next;
    logic               en;

    logic signed [15:0] qa_x, qa_y, qa_z, qa_w, qb_x, qb_y, qb_z, qb_w;
    logic [15:0]        blend;
    logic signed [31:0] prod [4];
    logic signed [19:0] dot;
    logic [19:0]        dabs;
    logic signed [20:0] omd;
    logic               neg;

    assign qa_x  = in_data[15:0];
    assign qa_y  = in_data[31:16];
    assign qa_z  = in_data[47:32];
    assign qa_w  = in_data[63:48];
    assign qb_x  = in_data[79:64];
    assign qb_y  = in_data[95:80];
    assign qb_z  = in_data[111:96];
    assign qb_w  = in_data[127:112];
    assign blend = in_data[143:128];

    assign en        = !v2_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v2_reg;
    assign out_item  = item_reg;

    assign prod[0] = qa_x * qb_x;
    assign prod[1] = qa_y * qb_y;
    assign prod[2] = qa_z * qb_z;
    assign prod[3] = qa_w * qb_w;

    always_comb
    begin
        dot = 20'(p_reg[0]) + 20'(p_reg[1]) + 20'(p_reg[2]) + 20'(p_reg[3]);
        neg = dot[19];
        dabs = neg ? 20'(-dot) : 20'(dot);
        omd = 21'sd16384 - $signed({1'b0, dabs});
        item_next.qa = a_reg;
        for (int k = 0; k < 4; k++)
        begin
            item_next.qb[k] = neg ? 17'(-$signed({b_reg[k][15], b_reg[k]}))
                                  : {b_reg[k][15], b_reg[k]};
        end
        item_next.t = t_reg;
        item_next.d = (dabs > 20'd16384) ? 15'd16384 : dabs[14:0];
        item_next.req = omd > $signed({6'b0, thr});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_reg[k] <= prod[k][31:14];
            end
            a_reg <= in_data[63:0];
            b_reg <= in_data[127:64];
            t_reg <= (blend > 16'd32768) ? 16'd32768 : blend;
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

endmodule

// File: rtl/core/qslerp_queue.sv
module qslerp_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qslerp_pkg::item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qslerp_pkg::item_t    out_item
);

    qslerp_pkg::item_t                 mem_reg [qslerp_pkg::QUEUE_DEPTH];
    logic [qslerp_pkg::QPTR_W-1:0]     wr_reg;
    logic [qslerp_pkg::QPTR_W-1:0]     rd_reg;
    logic [qslerp_pkg::QPTR_W:0]       cnt_reg;
    logic                              push;
    logic                              pop;

    assign in_ready  = cnt_reg != (qslerp_pkg::QPTR_W+1)'(qslerp_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/qslerp_back.sv
module qslerp_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qslerp_pkg::item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          out_data,
    output logic                 out_lin
);

    localparam int CW = qslerp_pkg::CW;
    localparam int TI = qslerp_pkg::TRIG_ITER;
    localparam int NS = qslerp_pkg::STAGES;

    logic                     en;
    logic [NS-1:0]            vld_reg;
    qslerp_pkg::item_t        car_reg [NS-2];

    // Square root of 2^60 - d^2 * 2^32, one result bit per stage.
    logic [62:0]              sq_n_reg [qslerp_pkg::SQ_STEPS+1];
    logic [62:0]              sq_r_reg [qslerp_pkg::SQ_STEPS+1];
    logic [29:0]              dd;

    // Vectoring CORDIC for acos.
    logic signed [CW-1:0]     vx_reg [1:TI];
    logic signed [CW-1:0]     vy_reg [1:TI];
    logic signed [CW-1:0]     vz_reg [1:TI];

    logic signed [CW-1:0]     th_reg;
    logic signed [CW-1:0]     tha_reg;
    logic signed [CW-1:0]     thb_reg;
    logic signed [51:0]       prod_a;
    logic signed [51:0]       prod_b;

    // Three rotation CORDIC lanes: sin(theta), sin(A), sin(B).
    logic signed [CW-1:0]     sx_reg [3][1:TI];
    logic signed [CW-1:0]     sy_reg [3][1:TI];
    logic signed [CW-1:0]     sz_reg [3][1:TI];

    // Two restoring dividers for the weights.
    logic [CW-1:0]            rem_reg [2][qslerp_pkg::DIV_STEPS+1];
    logic [29:0]              q_reg [2][qslerp_pkg::DIV_STEPS+1];
    logic                     zero_reg [2][qslerp_pkg::DIV_STEPS+1];
    logic                     full_reg [2][qslerp_pkg::DIV_STEPS+1];
    logic [CW-1:0]            den_reg [qslerp_pkg::DIV_STEPS+1];
    logic                     sph_reg [qslerp_pkg::DIV_STEPS+1];

    logic signed [47:0]       pa_reg [4];
    logic signed [48:0]       pb_reg [4];
    logic                     lin_reg;
    logic [3:0][15:0]         qc_reg;
    logic                     out_lin_reg;

    logic [30:0]              wa;
    logic [30:0]              wb;
    logic [30:0]              tw;
    logic signed [49:0]       acc [4];
    logic signed [19:0]       rnd [4];

    assign en        = !vld_reg[NS-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NS-1];
    assign out_data  = qc_reg;
    assign out_lin   = out_lin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            car_reg[0] <= in_item;
            for (int i = 1; i < NS - 2; i++)
            begin
                car_reg[i] <= car_reg[i-1];
            end
        end
    end

    // ---------------- square root ----------------
    assign dd = in_item.d * in_item.d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_n_reg[0] <= (63'd1 << 60) - {1'b0, dd, 32'd0};
            sq_r_reg[0] <= '0;
        end
    end

    // The radicand never exceeds 2^60, so the trial bits start there.
    for (genvar k = 0; k < qslerp_pkg::SQ_STEPS; k++)
    begin : g_sq
        logic [62:0] bitv;
        logic [62:0] trial;
        assign bitv  = 63'd1 << (60 - 2 * k);
        assign trial = sq_r_reg[k] + bitv;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_n_reg[k] >= trial)
                begin
                    sq_n_reg[k+1] <= sq_n_reg[k] - trial;
                    sq_r_reg[k+1] <= (sq_r_reg[k] >> 1) + bitv;
                end
                else
                begin
                    sq_n_reg[k+1] <= sq_n_reg[k];
                    sq_r_reg[k+1] <= sq_r_reg[k] >> 1;
                end
            end
        end
    end

    // ---------------- acos by vectoring ----------------
    for (genvar i = 0; i < TI; i++)
    begin : g_vec
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] at;
        if (i == 0)
        begin : g_first
            assign x = $signed({3'b0, car_reg[qslerp_pkg::IX_VEC].d, 16'd0});
            assign y = $signed({1'b0, sq_r_reg[qslerp_pkg::SQ_STEPS][32:0]});
            assign z = '0;
        end
        else
        begin : g_next
            assign x = vx_reg[i];
            assign y = vy_reg[i];
            assign z = vz_reg[i];
        end
        assign xs = x >>> i;
        assign ys = y >>> i;
        assign at = $signed({3'b0, qslerp_pkg::ATAN_Q30[i]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y > 0)
                begin
                    vx_reg[i+1] <= x + ys;
                    vy_reg[i+1] <= y - xs;
                    vz_reg[i+1] <= z + at;
                end
                else
                begin
                    vx_reg[i+1] <= x - ys;
                    vy_reg[i+1] <= y + xs;
                    vz_reg[i+1] <= z - at;
                end
            end
        end
    end

    // ---------------- partial angles ----------------
    assign prod_a = vz_reg[TI] * $signed({18'd0, 17'd32768 - {1'b0, car_reg[qslerp_pkg::IX_ANG-1].t}});
    assign prod_b = vz_reg[TI] * $signed({19'd0, car_reg[qslerp_pkg::IX_ANG-1].t});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_reg  <= vz_reg[TI];
            tha_reg <= prod_a[48:15];
            thb_reg <= prod_b[48:15];
        end
    end

    // ---------------- sines by rotation ----------------
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        for (genvar i = 0; i < TI; i++)
        begin : g_rot
            logic signed [CW-1:0] x;
            logic signed [CW-1:0] y;
            logic signed [CW-1:0] z;
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic signed [CW-1:0] at;
            if (i == 0)
            begin : g_first
                assign x = CW'(64'sd1 <<< 30);
                assign y = '0;
                assign z = (l == 0) ? th_reg : ((l == 1) ? tha_reg : thb_reg);
            end
            else
            begin : g_next
                assign x = sx_reg[l][i];
                assign y = sy_reg[l][i];
                assign z = sz_reg[l][i];
            end
            assign xs = x >>> i;
            assign ys = y >>> i;
            assign at = $signed({3'b0, qslerp_pkg::ATAN_Q30[i]});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z >= 0)
                    begin
                        sx_reg[l][i+1] <= x - ys;
                        sy_reg[l][i+1] <= y + xs;
                        sz_reg[l][i+1] <= z - at;
                    end
                    else
                    begin
                        sx_reg[l][i+1] <= x + ys;
                        sy_reg[l][i+1] <= y - xs;
                        sz_reg[l][i+1] <= z + at;
                    end
                end
            end
        end
    end

    // ---------------- weight division ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= sy_reg[0][TI];
            sph_reg[0] <= car_reg[qslerp_pkg::IX_DIV-1].req && (sy_reg[0][TI] > 0);
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l][0]  <= sy_reg[l+1][TI];
                q_reg[l][0]    <= '0;
                zero_reg[l][0] <= sy_reg[l+1][TI] <= 0;
                full_reg[l][0] <= sy_reg[l+1][TI] >= sy_reg[0][TI];
            end
        end
    end

    for (genvar j = 0; j < qslerp_pkg::DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j+1] <= den_reg[j];
                sph_reg[j+1] <= sph_reg[j];
            end
        end
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [CW-1:0] r2;
            assign r2 = {rem_reg[l][j][CW-2:0], 1'b0};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[l][j+1] <= zero_reg[l][j];
                    full_reg[l][j+1] <= full_reg[l][j];
                    if (r2 >= den_reg[j])
                    begin
                        rem_reg[l][j+1] <= r2 - den_reg[j];
                        q_reg[l][j+1]   <= {q_reg[l][j][28:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[l][j+1] <= r2;
                        q_reg[l][j+1]   <= {q_reg[l][j][28:0], 1'b0};
                    end
                end
            end
        end
    end

    function automatic logic [30:0] pick_weight(input logic zero, input logic full,
                                                 input logic [29:0] q);
        if (zero)
        begin
            return '0;
        end
        if (full)
        begin
            return 31'd1 << 30;
        end
        return {1'b0, q};
    endfunction

    // ---------------- blend ----------------
    always_comb
    begin
        tw = {car_reg[NS-3].t[15:0], 15'd0};
        if (sph_reg[qslerp_pkg::DIV_STEPS])
        begin
            wa = pick_weight(zero_reg[0][qslerp_pkg::DIV_STEPS],
                             full_reg[0][qslerp_pkg::DIV_STEPS],
                             q_reg[0][qslerp_pkg::DIV_STEPS]);
            wb = pick_weight(zero_reg[1][qslerp_pkg::DIV_STEPS],
                             full_reg[1][qslerp_pkg::DIV_STEPS],
                             q_reg[1][qslerp_pkg::DIV_STEPS]);
        end
        else
        begin
            wa = (31'd1 << 30) - tw;
            wb = tw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                pa_reg[k] <= $signed({1'b0, wa}) * $signed(car_reg[NS-3].qa[k]);
                pb_reg[k] <= $signed({1'b0, wb}) * $signed(car_reg[NS-3].qb[k]);
            end
            lin_reg <= !sph_reg[qslerp_pkg::DIV_STEPS];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            acc[k] = 50'(pa_reg[k]) + 50'(pb_reg[k]) + (50'sd1 <<< 29);
            rnd[k] = acc[k][49:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (rnd[k] > 20'sd32767)
                begin
                    qc_reg[k] <= 16'h7FFF;
                end
                else if (rnd[k] < -20'sd32768)
                begin
                    qc_reg[k] <= 16'h8000;
                end
                else
                begin
                    qc_reg[k] <= rnd[k][15:0];
                end
            end
            out_lin_reg <= lin_reg;
        end
    end

endmodule

// File: rtl/core/quaternion_slerp.sv
// Quaternion slerp engine, Q2.14 components, Q1.15 blend fraction.
// Input words arrive on the s_ group; a word is taken when s_tvalid and
// s_tready are both high. Each word carries one pair of quaternions and t.
// Results leave on the m_ group, one word per input word, in input order;
// m_tuser is high when plain linear weights were used.
// The threshold on one minus the dot product is written over the cfg_
// channel, which is always ready; write it only while the block is idle.
// Throughput is one word per cycle while nothing stalls. A word passes the
// product registers and the item register of the dot product front end,
// the queue, and then a 98 stage back end made of a 31 stage square root,
// a 16 stage acos CORDIC, the angle multipliers, three 16 stage sine
// CORDICs, a 30 stage divider for each weight, the weight multipliers and
// the rounding and saturating stage.
// The back end stalls as a whole while m_tvalid is high and m_tready is low;
// a four word queue between the two parts lets the front keep taking words
// until the queue fills, and then s_tready falls.
// Reset clears all valid flags and loads the threshold with 16.
module quaternion_slerp
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // qa_x, qa_y, qa_z, qa_w, qb_x, qb_y, qb_z, qb_w, blend
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // qc_x, qc_y, qc_z, qc_w
    output logic [63:0]  m_tdata,
    // used_linear
    output logic         m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    // linear_threshold in the low 15 bits
    input  logic [15:0]  cfg_data
);

    logic [14:0]        thr_reg;
    qslerp_pkg::item_t  f_item;
    qslerp_pkg::item_t  q_item;
    logic               f_valid;
    logic               f_ready;
    logic               q_valid;
    logic               q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= qslerp_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data[14:0];
        end
    end

    qslerp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .thr       (thr_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    qslerp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    qslerp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_lin   (m_tuser)
    );

endmodule
